// File: design/small_risc_instruction_step_assert.svh
// assertion macros used by the checker file of the small risc step block
`ifndef SMALL_RISC_INSTRUCTION_STEP_ASSERT_SVH
`define SMALL_RISC_INSTRUCTION_STEP_ASSERT_SVH

// generic clocked property, disabled while reset is low
`define SRISC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold whenever a result item is shown
`define SRISC_ASSERT_OUT(lbl, clk, rst_n, vld, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) vld |-> cond) else $error(msg);

`endif

// File: design/srisc_pkg.sv
// shared types, codes and constants of the small risc step block
package srisc_pkg;

  localparam int MEM_WORDS_DEF = 65536;
  localparam int REG_COUNT     = 8;
  localparam int RIDX_W        = 3;
  localparam int WORD_W        = 32;

  // instruction field positions
  localparam int OP_LSB  = 22;
  localparam int ILL_LSB = 25;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;
  localparam int OFF_W   = 16;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_STEP = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_HALTED  = 3'd1,
    ST_STOPPED = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_ACCESS  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        address;
    logic signed [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_data;
    logic signed [31:0] program_counter;
    logic [31:0]        executed_count;
    logic               reg_written;
    logic [2:0]         reg_index;
    logic signed [31:0] reg_value;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic fetch;
    logic decode;
    logic exec;
    logic mem_wr;
    logic mem_rd;
    logic mem_cap;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t in_act;
    logic    runnable;
    logic    wrap_done;
    action_t act;
    logic    is_lw;
    logic    is_sw;
  } dp_stat_t;

endpackage

// File: design/small_risc_instruction_step.sv
// top level: eight-register 32-bit core stepped one item at a time
// address reduction: for memory sizes that are not a power of two, each load, read, lw and sw
//   address goes through the wrap unit's estimate, back-multiply and correction steps
// one item at a time: the next item is taken once the result sits in the output register;
//   the single read port of the shared memory (fetch, then data access) sets the step length
// reset (rst_n low, synchronous) clears pc, program length, stop flag, count, register valid
//   bits and output valid; memory contents are left as they are and need no clearing pass
module small_risc_instruction_step #(
  parameter int MEM_WORDS = srisc_pkg::MEM_WORDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input item channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  srisc_pkg::in_item_t  in_data,
  // result item channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output srisc_pkg::out_item_t out_data
);

  // command and status bundles between sequencer and datapath
  srisc_pkg::ctrl_cmd_t cmd;
  srisc_pkg::dp_stat_t  stat;

  // sequencer: one-hot state machine, owns both handshakes
  //   idle -> wrap (load/read address reduction) -> memory write or read
  //   idle -> decode -> exec -> optional wrap for lw/sw -> memory access
  //   every path ends in the output state, which waits for a free output register
  srisc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: shared program/data memory, dual-copy register file, alu,
  // address wrap unit and the output item register
  srisc_dp #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// File: design/srisc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module srisc_ram #(
  parameter int WIDTH = srisc_pkg::WORD_W,
  parameter int DEPTH = srisc_pkg::MEM_WORDS_DEF
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/srisc_ctrl.sv
// sequencing state machine of the small risc step block
module srisc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  srisc_pkg::dp_stat_t   stat,
  output srisc_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_WRAP    = 7'b0000010,
    S_DECODE  = 7'b0000100,
    S_EXEC    = 7'b0001000,
    S_LSWRAP  = 7'b0010000,
    S_MEMWAIT = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (stat.in_act)
            srisc_pkg::ACT_LOAD,
            srisc_pkg::ACT_READ: state_nxt = S_WRAP;
            srisc_pkg::ACT_STEP: begin
              if (stat.runnable) begin
                cmd.fetch = 1'b1;
                state_nxt = S_DECODE;
              end else begin
                state_nxt = S_OUT;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_WRAP: begin
        if (stat.wrap_done) begin
          if (stat.act == srisc_pkg::ACT_LOAD) begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            cmd.mem_rd = 1'b1;
            state_nxt  = S_MEMWAIT;
          end
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = (stat.is_lw || stat.is_sw) ? S_LSWRAP : S_OUT;
      end
      S_LSWRAP: begin
        if (stat.wrap_done) begin
          if (stat.is_sw) begin
            cmd.mem_wr = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            cmd.mem_rd = 1'b1;
            state_nxt  = S_MEMWAIT;
          end
        end
      end
      S_MEMWAIT: begin
        cmd.mem_cap = 1'b1;
        state_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/srisc_dp.sv
// datapath: memory, register file, alu, address wrap unit and result register
module srisc_dp #(
  parameter int MEM_WORDS = srisc_pkg::MEM_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srisc_pkg::in_item_t   in_data,
  input  srisc_pkg::ctrl_cmd_t  cmd,
  output srisc_pkg::dp_stat_t   stat,
  output srisc_pkg::out_item_t  out_data
);

  localparam int AW      = $clog2(MEM_WORDS);
  localparam int PLEN_W  = $clog2(MEM_WORDS + 1);
  localparam bit IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;
  localparam int NSTEPS  = IS_POW2 ? 0 : 3;
  localparam int CNT_W   = 2;
  localparam int RW      = srisc_pkg::RIDX_W;
  localparam int WW      = srisc_pkg::WORD_W;
  localparam logic [2*WW-1:0] RECIP_FULL = (64'd1 << WW) / 64'(MEM_WORDS);
  localparam logic [WW-1:0]   RECIP      = RECIP_FULL[WW-1:0];

  // architectural state
  logic [WW-1:0]                  pc_r;
  logic [PLEN_W-1:0]              plen_r;
  logic                           stopped_r;
  logic [WW-1:0]                  icnt_r;
  logic [srisc_pkg::REG_COUNT-1:0] rvalid_r;

  // item and result registers
  srisc_pkg::action_t   act_r;
  logic [WW-1:0]        sdata_r;
  logic [WW-1:0]        ir_r;
  srisc_pkg::status_t   status_r;
  logic [WW-1:0]        rdata_r;
  logic                 wr_r;
  logic [RW-1:0]        widx_r;
  logic [WW-1:0]        wval_r;
  srisc_pkg::out_item_t out_r;

  // address wrap unit
  logic [WW-1:0]    rem_r;
  logic [WW-1:0]    quot_r;
  logic [2*WW-1:0]  quot_full;
  logic [WW-1:0]    quot_m;
  logic [CNT_W-1:0] mcnt_r;
  logic             wrap_start;
  logic [WW-1:0]    wrap_val;
  logic [AW-1:0]    wrap_addr;

  // memory and register file ports
  logic [WW-1:0] mem_q;
  logic [WW-1:0] rfa_q, rfb_q;
  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [WW-1:0] rf_wdata;

  // decode and execute
  srisc_pkg::opcode_t op;
  logic               illegal;
  logic [RW-1:0]      ra_idx, rb_idx, rd_idx;
  logic [WW-1:0]      a_val, b_val, off, pc_inc, ls_sum;
  logic               ls_op;
  logic [WW-1:0]      ex_pc;
  logic               ex_wr;
  logic [RW-1:0]      ex_idx;
  logic [WW-1:0]      ex_val;
  srisc_pkg::status_t ex_status;
  logic               ex_stop;
  logic               runnable;

  assign op      = srisc_pkg::opcode_t'(ir_r[srisc_pkg::OP_LSB +: 3]);
  assign illegal = |ir_r[WW-1:srisc_pkg::ILL_LSB];
  assign ra_idx  = ir_r[srisc_pkg::RA_LSB +: RW];
  assign rb_idx  = ir_r[srisc_pkg::RB_LSB +: RW];
  assign rd_idx  = ir_r[RW-1:0];
  // entries never written read as zero
  assign a_val   = rvalid_r[ra_idx] ? rfa_q : '0;
  assign b_val   = rvalid_r[rb_idx] ? rfb_q : '0;
  assign off     = {{(WW - srisc_pkg::OFF_W){ir_r[srisc_pkg::OFF_W-1]}},
                    ir_r[srisc_pkg::OFF_W-1:0]};
  assign pc_inc  = pc_r + 32'd1;
  assign ls_sum  = a_val + off;
  assign ls_op   = !illegal && (op == srisc_pkg::OP_LW || op == srisc_pkg::OP_SW);

  assign runnable = !stopped_r && !pc_r[WW-1] && (pc_r < WW'(plen_r));

  always_comb begin
    ex_pc     = pc_inc;
    ex_wr     = 1'b0;
    ex_idx    = '0;
    ex_val    = '0;
    ex_status = srisc_pkg::ST_DONE;
    ex_stop   = 1'b0;
    if (illegal) begin
      ex_pc     = pc_r;
      ex_status = srisc_pkg::ST_ILLEGAL;
      ex_stop   = 1'b1;
    end else begin
      case (op)
        srisc_pkg::OP_ADD: begin
          ex_wr  = 1'b1;
          ex_idx = rd_idx;
          ex_val = a_val + b_val;
        end
        srisc_pkg::OP_NOR: begin
          ex_wr  = 1'b1;
          ex_idx = rd_idx;
          ex_val = ~(a_val | b_val);
        end
        srisc_pkg::OP_LW: begin
          ex_idx = rb_idx;
        end
        srisc_pkg::OP_SW: begin
        end
        srisc_pkg::OP_BEQ: begin
          if (a_val == b_val) begin
            ex_pc = pc_inc + off;
          end
        end
        srisc_pkg::OP_JALR: begin
          ex_wr  = 1'b1;
          ex_idx = rb_idx;
          ex_val = pc_inc;
          if (ra_idx != rb_idx) begin
            ex_pc = a_val;
          end
        end
        srisc_pkg::OP_HALT: begin
          ex_stop   = 1'b1;
          ex_status = srisc_pkg::ST_HALTED;
        end
        srisc_pkg::OP_NOOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // address wrap: reciprocal quotient estimate, back-multiply, one corrective subtract
  assign wrap_start = cmd.accept || (cmd.exec && ls_op);
  assign wrap_val   = cmd.accept ? WW'(in_data.address) : ls_sum;
  assign wrap_addr  = rem_r[AW-1:0];
  assign quot_full  = {{WW{1'b0}}, rem_r} * {{WW{1'b0}}, RECIP};
  assign quot_m     = quot_r * WW'(MEM_WORDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mcnt_r <= '0;
    end else if (wrap_start) begin
      mcnt_r <= CNT_W'(NSTEPS);
    end else if (mcnt_r != '0) begin
      mcnt_r <= mcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wrap_start) begin
      rem_r <= wrap_val;
    end else if (mcnt_r == CNT_W'(2)) begin
      rem_r <= rem_r - quot_m;
    end else if (mcnt_r == CNT_W'(1) && rem_r >= WW'(MEM_WORDS)) begin
      rem_r <= rem_r - WW'(MEM_WORDS);
    end
    if (mcnt_r == CNT_W'(3)) begin
      quot_r <= quot_full[2*WW-1:WW];
    end
  end

  // main memory
  srisc_ram #(
    .WIDTH (WW),
    .DEPTH (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .we    (cmd.mem_wr),
    .waddr (wrap_addr),
    .wdata (sdata_r),
    .re    (cmd.fetch || cmd.mem_rd),
    .raddr (cmd.fetch ? pc_r[AW-1:0] : wrap_addr),
    .rdata (mem_q)
  );

  // register file, one copy per read port
  assign rf_we    = (cmd.exec && ex_wr) || (cmd.mem_cap && act_r == srisc_pkg::ACT_STEP);
  assign rf_waddr = cmd.exec ? ex_idx : widx_r;
  assign rf_wdata = cmd.exec ? ex_val : mem_q;

  srisc_ram #(
    .WIDTH (WW),
    .DEPTH (srisc_pkg::REG_COUNT)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (cmd.decode),
    .raddr (mem_q[srisc_pkg::RA_LSB +: RW]),
    .rdata (rfa_q)
  );

  srisc_ram #(
    .WIDTH (WW),
    .DEPTH (srisc_pkg::REG_COUNT)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (cmd.decode),
    .raddr (mem_q[srisc_pkg::RB_LSB +: RW]),
    .rdata (rfb_q)
  );

  // architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      plen_r    <= '0;
      stopped_r <= 1'b0;
      icnt_r    <= '0;
      rvalid_r  <= '0;
    end else begin
      if (cmd.exec) begin
        pc_r   <= ex_pc;
        icnt_r <= icnt_r + 32'd1;
        if (ex_stop) begin
          stopped_r <= 1'b1;
        end
      end
      if (cmd.mem_wr && plen_r <= PLEN_W'(wrap_addr)) begin
        plen_r <= PLEN_W'(wrap_addr) + 1'b1;
      end
      if (rf_we) begin
        rvalid_r[rf_waddr] <= 1'b1;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r    <= srisc_pkg::action_t'(in_data.action);
      sdata_r  <= in_data.data;
      rdata_r  <= '0;
      wr_r     <= 1'b0;
      widx_r   <= '0;
      wval_r   <= '0;
      if (in_data.action == srisc_pkg::ACT_STEP) begin
        status_r <= runnable ? srisc_pkg::ST_DONE : srisc_pkg::ST_STOPPED;
      end else begin
        status_r <= srisc_pkg::ST_ACCESS;
      end
    end
    if (cmd.decode) begin
      ir_r <= mem_q;
    end
    if (cmd.exec) begin
      status_r <= ex_status;
      wr_r     <= ex_wr;
      widx_r   <= ex_idx;
      wval_r   <= ex_val;
      if (ls_op && op == srisc_pkg::OP_SW) begin
        sdata_r <= b_val;
      end
    end
    if (cmd.mem_cap) begin
      if (act_r == srisc_pkg::ACT_STEP) begin
        wr_r   <= 1'b1;
        wval_r <= mem_q;
      end else begin
        rdata_r <= mem_q;
      end
    end
    if (cmd.out_load) begin
      out_r.status          <= status_r;
      out_r.read_data       <= rdata_r;
      out_r.program_counter <= pc_r;
      out_r.executed_count  <= icnt_r;
      out_r.reg_written     <= wr_r;
      out_r.reg_index       <= widx_r;
      out_r.reg_value       <= wval_r;
    end
  end

  assign stat.in_act    = srisc_pkg::action_t'(in_data.action);
  assign stat.runnable  = runnable;
  assign stat.wrap_done = (mcnt_r == '0);
  assign stat.act       = act_r;
  assign stat.is_lw     = !illegal && op == srisc_pkg::OP_LW;
  assign stat.is_sw     = !illegal && op == srisc_pkg::OP_SW;

  assign out_data = out_r;

endmodule

// File: design/srisc_checker.sv
// port-level checker of the small risc step block and its bind
`include "small_risc_instruction_step_assert.svh"

module srisc_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input srisc_pkg::out_item_t out_data
);

  `SRISC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result item dropped while stalled")
  `SRISC_ASSERT(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result item changed")
  `SRISC_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "input item taken while previous still in work")
  `SRISC_ASSERT_OUT(a_wr_only_done, clk, rst_n, out_valid && out_data.reg_written, out_data.status == srisc_pkg::ST_DONE, "register write reported on a step that did not run")
  `SRISC_ASSERT_OUT(a_rdata_only_access, clk, rst_n, out_valid && out_data.read_data != 32'sd0, out_data.status == srisc_pkg::ST_ACCESS, "read data shown on a step result")

endmodule

bind small_risc_instruction_step srisc_checker u_srisc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: sim/small_risc_instruction_step_test.sv
// testbench of the small risc step block: directed program, random programs, scoreboard check
`timescale 1ns / 100ps

module small_risc_instruction_step_test;

  localparam int unsigned MEM          = srisc_pkg::MEM_WORDS_DEF;
  localparam int unsigned DATA_BASE    = 32'h100;   // small data window for lw and sw
  localparam int unsigned RANDOM_UNTIL = 640;       // items sent before the wrap-up sequence
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;      // action code with no meaning

  // how the run ends: each of these stops the core for good
  typedef enum {END_HALT, END_ILLEGAL, END_NEG_PC} wrap_up_t;
  // receiver stall patterns
  typedef enum {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  typedef struct {
    srisc_pkg::in_item_t  item;
    bit                   typed;   // expectation written in the row, not from the core model
    srisc_pkg::out_item_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  srisc_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  srisc_pkg::out_item_t out_data;

  // core model state, kept in step with every accepted item
  bit [31:0]   core_mem [MEM];
  bit          core_set [MEM];   // word written at least once
  bit [31:0]   core_regs [srisc_pkg::REG_COUNT];
  bit [31:0]   core_pc;
  int unsigned core_len;
  bit          core_stopped;
  bit [31:0]   core_count;
  int unsigned written_addrs [$];

  srisc_pkg::out_item_t results_due [$];
  int unsigned fail_count  = 0;
  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;

  small_risc_instruction_step dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic srisc_pkg::in_item_t item_of(logic [1:0] act, logic [15:0] adr,
                                                  logic [31:0] d);
    srisc_pkg::in_item_t it;
    it.action  = act;
    it.address = adr;
    it.data    = d;
    return it;
  endfunction

  function automatic logic [31:0] encode(srisc_pkg::opcode_t op, logic [2:0] ra,
                                         logic [2:0] rb, logic [15:0] low);
    return {7'b0, op, ra, rb, low};
  endfunction

  function automatic logic [31:0] offset_of(logic [31:0] ins);
    return {{16{ins[srisc_pkg::OFF_W-1]}}, ins[srisc_pkg::OFF_W-1:0]};
  endfunction

  // wrapped data address of an lw or sw under the current registers
  function automatic int unsigned data_addr(logic [31:0] ins);
    return (core_regs[ins[srisc_pkg::RA_LSB +: 3]] + offset_of(ins)) % MEM;
  endfunction

  // result of an item that runs no instruction while pc and count are still zero
  function automatic srisc_pkg::out_item_t quiet_result(srisc_pkg::status_t s,
                                                        logic [31:0] rd);
    srisc_pkg::out_item_t r;
    r = '0;
    r.status    = s;
    r.read_data = rd;
    return r;
  endfunction

  function automatic void store_word(logic [31:0] a, logic [31:0] v);
    int unsigned w;
    w = a % MEM;
    core_mem[w] = v;
    if (!core_set[w]) begin
      core_set[w] = 1'b1;
      written_addrs.push_back(w);
    end
    // load and sw both grow the program
    if (core_len <= w) core_len = w + 1;
  endfunction

  // one item through the core model, returns the result it must produce
  task automatic step_core(input srisc_pkg::in_item_t it, output srisc_pkg::out_item_t res);
    logic [31:0]        ins, a_val, b_val, wval;
    logic [2:0]         ra, rb, dst;
    srisc_pkg::opcode_t op;
    bit                 wrote;
    res   = '0;
    res.status = srisc_pkg::ST_ACCESS;
    wrote = 1'b0;
    dst   = '0;
    wval  = '0;
    case (it.action)
      srisc_pkg::ACT_LOAD: store_word(32'(it.address), it.data);
      srisc_pkg::ACT_READ: res.read_data = core_mem[it.address % MEM];
      srisc_pkg::ACT_STEP: begin
        // stopped, negative pc or pc past the program: nothing happens
        if (core_stopped || core_pc[31] || core_pc >= core_len) begin
          res.status = srisc_pkg::ST_STOPPED;
        end else begin
          ins   = core_mem[core_pc % MEM];
          ra    = ins[srisc_pkg::RA_LSB +: 3];
          rb    = ins[srisc_pkg::RB_LSB +: 3];
          a_val = core_regs[ra];
          b_val = core_regs[rb];
          op    = srisc_pkg::opcode_t'(ins[srisc_pkg::OP_LSB +: 3]);
          core_count++;
          res.status = srisc_pkg::ST_DONE;
          if (ins[31:srisc_pkg::ILL_LSB] != '0) begin
            // opcode above seven: counted, pc held, core stops
            core_stopped = 1'b1;
            res.status   = srisc_pkg::ST_ILLEGAL;
          end else begin
            case (op)
              srisc_pkg::OP_ADD: begin
                wrote = 1'b1;
                dst   = ins[2:0];
                wval  = a_val + b_val;
              end
              srisc_pkg::OP_NOR: begin
                wrote = 1'b1;
                dst   = ins[2:0];
                wval  = ~(a_val | b_val);
              end
              srisc_pkg::OP_LW: begin
                wrote = 1'b1;
                dst   = rb;
                wval  = core_mem[data_addr(ins)];
              end
              srisc_pkg::OP_SW: store_word(data_addr(ins), b_val);
              srisc_pkg::OP_JALR: begin
                wrote = 1'b1;
                dst   = rb;
                wval  = core_pc + 1;
              end
              srisc_pkg::OP_HALT: begin
                core_stopped = 1'b1;
                res.status   = srisc_pkg::ST_HALTED;
              end
              default: ;
            endcase
            if (op == srisc_pkg::OP_BEQ && a_val == b_val)
              core_pc = core_pc + 1 + offset_of(ins);
            else if (op == srisc_pkg::OP_JALR && ra != rb) core_pc = a_val;
            else core_pc = core_pc + 1;
            if (wrote) core_regs[dst] = wval;
          end
        end
      end
      default: ;
    endcase
    res.program_counter = core_pc;
    res.executed_count  = core_count;
    res.reg_written     = wrote;
    res.reg_index       = dst;
    res.reg_value       = wval;
  endtask

  // true when the instruction at pc keeps the core running with pc in reach of a load
  function automatic bit stays_in_bounds(logic [31:0] ins);
    logic [31:0] ra_v, rb_v, nxt;
    ra_v = core_regs[ins[srisc_pkg::RA_LSB +: 3]];
    rb_v = core_regs[ins[srisc_pkg::RB_LSB +: 3]];
    nxt  = core_pc + 1;
    if (ins[31:srisc_pkg::ILL_LSB] != '0) return 1'b0;
    case (srisc_pkg::opcode_t'(ins[srisc_pkg::OP_LSB +: 3]))
      srisc_pkg::OP_HALT: return 1'b0;
      srisc_pkg::OP_BEQ:  if (ra_v == rb_v) nxt = core_pc + 1 + offset_of(ins);
      srisc_pkg::OP_JALR:
        if (ins[srisc_pkg::RA_LSB +: 3] != ins[srisc_pkg::RB_LSB +: 3]) nxt = ra_v;
      default: ;
    endcase
    // leave room for one more word after pc so the wrap-up always fits
    return nxt <= MEM - 2;
  endfunction

  function automatic logic [31:0] random_word();
    return $urandom_range(0, 1) ? 32'($urandom_range(0, 63)) : 32'($urandom);
  endfunction

  // any legal instruction but halt, fields random, branches and data aimed at small windows
  function automatic logic [31:0] random_instr(int unsigned at);
    srisc_pkg::opcode_t op;
    logic [2:0]         ra, rb;
    logic [15:0]        low;
    int                 target;
    do op = srisc_pkg::opcode_t'($urandom_range(0, 7)); while (op == srisc_pkg::OP_HALT);
    ra  = 3'($urandom);
    rb  = 3'($urandom);
    low = 16'($urandom);
    case (op)
      srisc_pkg::OP_LW, srisc_pkg::OP_SW: begin
        if ($urandom_range(0, 1)) low = 16'(DATA_BASE + $urandom_range(0, 63) - core_regs[ra]);
      end
      srisc_pkg::OP_BEQ: begin
        if (at < 30000) target = $urandom_range(0, 63) - int'(at) - 1;
        else target = $urandom_range(0, 16) - 8;
        low = target[15:0];
      end
      default: ;
    endcase
    return encode(op, ra, rb, low);
  endfunction

  // offer one item in bursts with random gaps, record what it must produce
  task automatic send_item(input srisc_pkg::in_item_t it, input bit typed = 1'b0,
                           input srisc_pkg::out_item_t want = '0);
    srisc_pkg::out_item_t predicted;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall !== 1'b0);
    step_core(it, predicted);
    results_due.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got === want) return 1'b1;
    $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
    return 1'b0;
  endfunction

  function automatic void check_result(srisc_pkg::out_item_t want, srisc_pkg::out_item_t got);
    bit ok;
    ok = field_ok("status", 32'(want.status), 32'(got.status));
    ok &= field_ok("read_data", want.read_data, got.read_data);
    ok &= field_ok("program_counter", want.program_counter, got.program_counter);
    ok &= field_ok("executed_count", want.executed_count, got.executed_count);
    ok &= field_ok("reg_written", 32'(want.reg_written), 32'(got.reg_written));
    ok &= field_ok("reg_index", 32'(want.reg_index), 32'(got.reg_index));
    ok &= field_ok("reg_value", want.reg_value, got.reg_value);
    if (!ok) fail_count++;
  endfunction

  // result side: every accepted result against the oldest one due
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        $error("result item arrived with none due");
        fail_count++;
      end else begin
        check_result(results_due.pop_front(), out_data);
      end
    end
  end

  // receiver stalls: changing patterns, with one long hold-off so the block backs up
  initial begin
    stall_mode_t mode;
    int          span;
    int          rounds;
    out_stall = 1'b0;
    rounds    = 0;
    @(posedge rst_n);
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          FLOW:    out_stall = 1'b0;
          LIGHT:   out_stall = ($urandom_range(0, 3) == 0);
          HEAVY:   out_stall = 1'($urandom_range(0, 1));
          default: out_stall = (k % 4 != 3);
        endcase
      end
      rounds++;
      if (rounds == 4) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t    directed [$];
    int unsigned here, spot;
    int unsigned pick;
    logic [31:0] ins, w;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;

    // empty program: the first step finds pc past the program
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_STEP, 16'h0, 32'h0), 1'b1,
                                  quiet_result(srisc_pkg::ST_STOPPED, 32'h0)});
    // unused action code touches nothing
    directed.push_back(dir_row_t'{item_of(ACT_UNUSED, 16'hFFFF, 32'hFFFF_FFFF), 1'b1,
                                  quiet_result(srisc_pkg::ST_ACCESS, 32'h0)});
    // extreme address and data; the top word makes the whole memory runnable
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'hFFFF, 32'h8000_0000), 1'b1,
                                  quiet_result(srisc_pkg::ST_ACCESS, 32'h0)});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'h8000, 32'h7FFF_FFFF), 1'b1,
                                  quiet_result(srisc_pkg::ST_ACCESS, 32'h0)});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_READ, 16'hFFFF, 32'h0), 1'b1,
                                  quiet_result(srisc_pkg::ST_ACCESS, 32'h8000_0000)});
    // short program covering every operation except the stopping ones
    // lw with the most negative offset wraps to 0x8000, offset -1 wraps to 0xFFFF
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd0,
                                  encode(srisc_pkg::OP_LW, 3'd0, 3'd1, 16'h8000)), 1'b0, '0});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd1,
                                  encode(srisc_pkg::OP_LW, 3'd0, 3'd2, 16'hFFFF)), 1'b0, '0});
    // add overflows
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd2,
                                  encode(srisc_pkg::OP_ADD, 3'd1, 3'd1, 16'h0004)), 1'b0, '0});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd3,
                                  encode(srisc_pkg::OP_NOR, 3'd1, 3'd2, 16'h0005)), 1'b0, '0});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd4,
                                  encode(srisc_pkg::OP_SW, 3'd0, 3'd2, 16'd20)), 1'b0, '0});
    // taken branch skips word 6
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd5,
                                  encode(srisc_pkg::OP_BEQ, 3'd0, 3'd5, 16'd1)), 1'b0, '0});
    // jalr with the same register on both sides just links and falls through
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd7,
                                  encode(srisc_pkg::OP_JALR, 3'd3, 3'd3, 16'h0)), 1'b0, '0});
    // register zero is written like any other
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd8,
                                  encode(srisc_pkg::OP_ADD, 3'd3, 3'd3, 16'h0000)), 1'b0, '0});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd9,
                                  encode(srisc_pkg::OP_NOOP, 3'd7, 3'd7, 16'hFFFF)), 1'b0, '0});
    directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_LOAD, 16'd10,
                                  encode(srisc_pkg::OP_JALR, 3'd3, 3'd7, 16'h0)), 1'b0, '0});
    repeat (10)
      directed.push_back(dir_row_t'{item_of(srisc_pkg::ACT_STEP, 16'h0, 32'h0), 1'b0, '0});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].typed, directed[i].want);

    // random programs: mostly steps, with the code and data they need loaded just in time
    while (items_sent < RANDOM_UNTIL) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        here = core_pc % MEM;
        ins  = core_mem[here];
        if (!core_set[here] || $urandom_range(0, 9) == 0 || !stays_in_bounds(ins))
          send_item(item_of(srisc_pkg::ACT_LOAD, 16'(here), random_instr(here)));
        else if (srisc_pkg::opcode_t'(ins[srisc_pkg::OP_LSB +: 3]) == srisc_pkg::OP_LW &&
                 !core_set[data_addr(ins)])
          send_item(item_of(srisc_pkg::ACT_LOAD, 16'(data_addr(ins)), random_word()));
        else
          send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
      end else if (pick < 82) begin
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'($urandom), $urandom));
      end else if (pick < 94) begin
        // read back only words that hold something
        w = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        send_item(item_of(srisc_pkg::ACT_READ, w[15:0], $urandom));
      end else if (pick < 97) begin
        send_item(item_of(ACT_UNUSED, 16'($urandom), $urandom));
      end else begin
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(DATA_BASE + $urandom_range(0, 63)),
                          random_word()));
      end
    end

    // wrap-up: stop the core one way, then check it stays stopped while memory still works
    here = core_pc % MEM;
    case (wrap_up_t'($urandom_range(0, 2)))
      END_HALT: begin
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(here),
                          encode(srisc_pkg::OP_HALT, 3'($urandom), 3'($urandom),
                                 16'($urandom))));
        send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
      end
      END_ILLEGAL: begin
        w = $urandom;
        w[31:srisc_pkg::ILL_LSB] = 7'($urandom_range(1, 127));
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(here), w));
        send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
      end
      default: begin
        // lw a negative word into r6, then jalr through it: pc goes negative
        spot = (here + 2) % MEM;
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(spot), {1'b1, 31'($urandom)}));
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(here),
                          encode(srisc_pkg::OP_LW, 3'd0, 3'd6, 16'(spot - core_regs[0]))));
        send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
        send_item(item_of(srisc_pkg::ACT_LOAD, 16'(here + 1),
                          encode(srisc_pkg::OP_JALR, 3'd6, 3'd7, 16'h0)));
        send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
      end
    endcase
    repeat (2) send_item(item_of(srisc_pkg::ACT_STEP, 16'($urandom), $urandom));
    w = $urandom;
    send_item(item_of(srisc_pkg::ACT_LOAD, w[15:0], $urandom));
    send_item(item_of(srisc_pkg::ACT_READ, w[15:0], $urandom));
    send_item(item_of(srisc_pkg::ACT_READ, 16'(here), $urandom));

    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
